### hw/rtl/pwot_pkg.sv
// Shared types, field widths, request and status codes for the pending write overlap table.
`default_nettype none

package pwot_pkg;

    localparam int TYPE_W   = 2;
    localparam int ADDR_W   = 32;
    localparam int SEQ_W    = 32;
    localparam int OFF_W    = 2;
    localparam int COUNT_W  = 3;
    localparam int MASK_W   = 4;
    localparam int STAT_W   = 2;

    // Request codes
    localparam logic [TYPE_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_DELETE = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_PICK   = 2'd2;
    localparam logic [TYPE_W-1:0] REQ_CHECK  = 2'd3;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;

    // Payload of one table entry
    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [SEQ_W-1:0]   seq;
        logic [OFF_W-1:0]   off;
        logic [COUNT_W-1:0] cnt;
    } pwot_data_t;

    // Entry as seen on the read port: valid bit plus payload
    typedef struct packed {
        logic       valid;
        pwot_data_t data;
    } pwot_entry_t;

    // Write command from the sequencer to the store
    typedef struct packed {
        logic       en;
        logic       set;    // 1: store entry and mark valid, 0: invalidate
        pwot_data_t data;
    } pwot_wr_t;

    // Result of comparing one entry against the active request
    typedef struct packed {
        logic              stop;
        logic              hit;
        logic [MASK_W-1:0] mask;
    } pwot_match_t;

    // Slot mask of a run, bits at or above slots dropped, low MASK_W bits kept
    function automatic logic [MASK_W-1:0] run_mask(
        input logic [OFF_W-1:0]   off,
        input logic [COUNT_W-1:0] cnt,
        input int                 slots
    );
        logic [MASK_W-1:0] m;
        int lo;
        int hi;
        lo = int'(off);
        hi = lo + int'(cnt);
        for (int b = 0; b < MASK_W; b++)
        begin
            m[b] = (b < slots) && (b >= lo) && (b < hi);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/pwot_if.sv
// Request and response channel interfaces for the pending write overlap table.
`default_nettype none

interface pwot_req_if;
    import pwot_pkg::*;

    logic               valid;
    logic               ready;
    logic [TYPE_W-1:0]  req_type;
    logic [ADDR_W-1:0]  page_addr;
    logic [OFF_W-1:0]   slot_offset;
    logic [COUNT_W-1:0] slot_count;
    logic [SEQ_W-1:0]   seq_num;

    modport source (
        output valid, req_type, page_addr, slot_offset, slot_count, seq_num,
        input  ready
    );

    modport sink (
        input  valid, req_type, page_addr, slot_offset, slot_count, seq_num,
        output ready
    );
endinterface

interface pwot_rsp_if;
    import pwot_pkg::*;

    logic              valid;
    logic              ready;
    logic              hit;
    logic [MASK_W-1:0] cover_mask;
    logic [STAT_W-1:0] status;

    modport source (
        output valid, hit, cover_mask, status,
        input  ready
    );

    modport sink (
        input  valid, hit, cover_mask, status,
        output ready
    );
endinterface

`default_nettype wire

### hw/rtl/pwot_store.sv
// Entry memory with registered read port and per-entry valid flops.
`default_nettype none

module pwot_store #(
    parameter int ENTRIES = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         rd_en,
    input  wire logic [$clog2(ENTRIES)-1:0]   rd_idx,
    output pwot_pkg::pwot_entry_t             rd_data,
    input  wire pwot_pkg::pwot_wr_t           wr,
    input  wire logic [$clog2(ENTRIES)-1:0]   wr_idx
);
    import pwot_pkg::*;

    pwot_data_t        entry_mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    pwot_entry_t       rd_data_reg;

    // Set or clear the valid bit of the written entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr_idx] <= wr.set;
        end
    end

    // Write payload on insert, read one entry per cycle
    always_ff @(posedge clk)
    begin
        if (wr.en && wr.set)
        begin
            entry_mem[wr_idx] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg.valid <= valid_reg[rd_idx];
            rd_data_reg.data  <= entry_mem[rd_idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### hw/rtl/pwot_match.sv
// Shared compare unit: tests one entry against the active request.
`default_nettype none

module pwot_match #(
    parameter int SLOTS = 4
) (
    input  wire pwot_pkg::pwot_entry_t         entry,
    input  wire logic [pwot_pkg::TYPE_W-1:0]   req_type,
    input  wire logic [pwot_pkg::ADDR_W-1:0]   page_addr,
    input  wire logic [pwot_pkg::SEQ_W-1:0]    seq_num,
    output pwot_pkg::pwot_match_t              result
);
    import pwot_pkg::*;

    logic addr_eq;
    logic seq_eq;
    logic seq_lt;

    assign addr_eq = entry.valid && (entry.data.addr == page_addr);
    assign seq_eq  = (entry.data.seq == seq_num);
    assign seq_lt  = (entry.data.seq < seq_num);

    // Decode per request type
    always_comb
    begin
        result = '0;
        case (req_type)
            REQ_INSERT:
            begin
                result.stop = !entry.valid;
            end
            REQ_DELETE:
            begin
                result.stop = addr_eq && seq_eq;
                result.hit  = addr_eq && seq_eq;
            end
            REQ_PICK:
            begin
                result.hit = addr_eq;
                if (addr_eq && seq_lt)
                begin
                    result.mask = run_mask(entry.data.off, entry.data.cnt, SLOTS);
                end
            end
            REQ_CHECK:
            begin
                result.hit = addr_eq;
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/pwot_ctrl.sv
// Scan sequencer: walks the table one entry per cycle and builds the response.
`default_nettype none

module pwot_ctrl #(
    parameter int ENTRIES = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    pwot_req_if.sink                          req,
    pwot_rsp_if.source                        rsp,
    output logic                              rd_en,
    output logic [$clog2(ENTRIES)-1:0]        rd_idx,
    input  wire pwot_pkg::pwot_match_t        match,
    output logic [pwot_pkg::TYPE_W-1:0]       cur_type,
    output logic [pwot_pkg::ADDR_W-1:0]       cur_addr,
    output logic [pwot_pkg::SEQ_W-1:0]        cur_seq,
    output pwot_pkg::pwot_wr_t                wr,
    output logic [$clog2(ENTRIES)-1:0]        wr_idx
);
    import pwot_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESULT
    } state_t;

    state_t             state_reg,    state_next;
    logic [TYPE_W-1:0]  type_reg,     type_next;
    logic [ADDR_W-1:0]  addr_reg,     addr_next;
    logic [SEQ_W-1:0]   seq_reg,      seq_next;
    logic [OFF_W-1:0]   off_reg,      off_next;
    logic [COUNT_W-1:0] cnt_reg,      cnt_next;
    logic [CNT_W-1:0]   idx_reg,      idx_next;
    logic               cmp_live_reg, cmp_live_next;
    logic [IDX_W-1:0]   cmp_idx_reg,  cmp_idx_next;
    logic               hit_reg,      hit_next;
    logic [MASK_W-1:0]  mask_reg,     mask_next;
    logic [STAT_W-1:0]  status_reg,   status_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_hit_reg,   out_hit_next;
    logic [MASK_W-1:0]  out_mask_reg,  out_mask_next;
    logic [STAT_W-1:0]  out_status_reg, out_status_next;

    // Next-state logic
    always_comb
    begin
        state_next      = state_reg;
        type_next       = type_reg;
        addr_next       = addr_reg;
        seq_next        = seq_reg;
        off_next        = off_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        cmp_live_next   = cmp_live_reg;
        cmp_idx_next    = cmp_idx_reg;
        hit_next        = hit_reg;
        mask_next       = mask_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_hit_next    = out_hit_reg;
        out_mask_next   = out_mask_reg;
        out_status_next = out_status_reg;
        rd_en           = 1'b0;
        wr              = '0;
        wr.data.addr    = addr_reg;
        wr.data.seq     = seq_reg;
        wr.data.off     = off_reg;
        wr.data.cnt     = cnt_reg;

        case (state_reg)
            S_IDLE:
            begin
                // Latch the request and start the scan at entry zero
                if (req.valid)
                begin
                    type_next     = req.req_type;
                    addr_next     = req.page_addr;
                    seq_next      = req.seq_num;
                    off_next      = req.slot_offset;
                    cnt_next      = req.slot_count;
                    idx_next      = '0;
                    cmp_live_next = 1'b0;
                    hit_next      = 1'b0;
                    mask_next     = '0;
                    status_next   = (req.req_type == REQ_INSERT) ? STAT_FULL : STAT_NOT_FOUND;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // Issue the read of the next entry
                if (idx_reg < CNT_W'(ENTRIES))
                begin
                    rd_en         = 1'b1;
                    idx_next      = idx_reg + CNT_W'(1);
                    cmp_live_next = 1'b1;
                    cmp_idx_next  = idx_reg[IDX_W-1:0];
                end
                else
                begin
                    cmp_live_next = 1'b0;
                end
                // Evaluate the entry read in the previous cycle
                if (cmp_live_reg)
                begin
                    if (match.hit)
                    begin
                        hit_next    = 1'b1;
                        status_next = STAT_OK;
                    end
                    mask_next = mask_reg | match.mask;
                    if (match.stop)
                    begin
                        wr.en       = 1'b1;
                        wr.set      = (type_reg == REQ_INSERT);
                        status_next = STAT_OK;
                        state_next  = S_RESULT;
                    end
                    else if (cmp_idx_reg == IDX_W'(ENTRIES - 1))
                    begin
                        state_next = S_RESULT;
                    end
                end
            end
            S_RESULT:
            begin
                // Hand the result to the output register once it is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_hit_next    = hit_reg;
                    out_mask_next   = mask_reg;
                    out_status_next = status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            type_reg       <= REQ_INSERT;
            addr_reg       <= '0;
            seq_reg        <= '0;
            off_reg        <= '0;
            cnt_reg        <= '0;
            idx_reg        <= '0;
            cmp_live_reg   <= 1'b0;
            cmp_idx_reg    <= '0;
            hit_reg        <= 1'b0;
            mask_reg       <= '0;
            status_reg     <= STAT_OK;
            out_valid_reg  <= 1'b0;
            out_hit_reg    <= 1'b0;
            out_mask_reg   <= '0;
            out_status_reg <= STAT_OK;
        end
        else
        begin
            state_reg      <= state_next;
            type_reg       <= type_next;
            addr_reg       <= addr_next;
            seq_reg        <= seq_next;
            off_reg        <= off_next;
            cnt_reg        <= cnt_next;
            idx_reg        <= idx_next;
            cmp_live_reg   <= cmp_live_next;
            cmp_idx_reg    <= cmp_idx_next;
            hit_reg        <= hit_next;
            mask_reg       <= mask_next;
            status_reg     <= status_next;
            out_valid_reg  <= out_valid_next;
            out_hit_reg    <= out_hit_next;
            out_mask_reg   <= out_mask_next;
            out_status_reg <= out_status_next;
        end
    end

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.hit        = out_hit_reg;
    assign rsp.cover_mask = out_mask_reg;
    assign rsp.status     = out_status_reg;
    assign rd_idx         = idx_reg[IDX_W-1:0];
    assign wr_idx         = cmp_idx_reg;
    assign cur_type       = type_reg;
    assign cur_addr       = addr_reg;
    assign cur_seq        = seq_reg;

endmodule

`default_nettype wire

### hw/rtl/pending_write_overlap_table.sv
// Top level of the pending write overlap table.
//
// Usage:
//   req carries one transaction per request: insert, delete, pick or check,
//   with page address, slot run and sequence number. rsp returns exactly one
//   transaction per request: hit flag, cover mask and status.
//   The block holds one request at a time; req.ready is high only while idle.
//   Each request walks the table one entry per cycle through the entry
//   memory's single read port and one shared compare unit. Insert and
//   delete stop at the first free or matching entry; pick and check scan
//   every entry. The block takes no new request until the last one has
//   reached the result register and the block is back in idle.
//   The result waits in an output register; if rsp is stalled, the next
//   request is still accepted and scanned, and its result is held back until
//   the output register frees up.
//   Reset clears all valid bits at once; no clearing pass is needed, and the
//   block is ready as soon as reset is released.
`default_nettype none

module pending_write_overlap_table #(
    parameter int ENTRIES = 16,
    parameter int SLOTS   = 4
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    pwot_req_if.sink   req,
    pwot_rsp_if.source rsp
);
    import pwot_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);

    logic               rd_en;
    logic [IDX_W-1:0]   rd_idx;
    pwot_entry_t        rd_data;
    pwot_wr_t           wr;
    logic [IDX_W-1:0]   wr_idx;
    pwot_match_t        match;
    logic [TYPE_W-1:0]  cur_type;
    logic [ADDR_W-1:0]  cur_addr;
    logic [SEQ_W-1:0]   cur_seq;

    pwot_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp      (rsp),
        .rd_en    (rd_en),
        .rd_idx   (rd_idx),
        .match    (match),
        .cur_type (cur_type),
        .cur_addr (cur_addr),
        .cur_seq  (cur_seq),
        .wr       (wr),
        .wr_idx   (wr_idx)
    );

    pwot_store #(
        .ENTRIES (ENTRIES)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_idx  (rd_idx),
        .rd_data (rd_data),
        .wr      (wr),
        .wr_idx  (wr_idx)
    );

    pwot_match #(
        .SLOTS (SLOTS)
    ) u_match (
        .entry     (rd_data),
        .req_type  (cur_type),
        .page_addr (cur_addr),
        .seq_num   (cur_seq),
        .result    (match)
    );

endmodule

`default_nettype wire

### hw/rtl/pwot_checker.sv
// Port-level checker for the pending write overlap table, bound to the top level.
`default_nettype none

module pwot_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         req_valid,
    input wire logic                         req_ready,
    input wire logic                         rsp_valid,
    input wire logic                         rsp_ready,
    input wire logic                         rsp_hit,
    input wire logic [pwot_pkg::MASK_W-1:0]  rsp_cover_mask,
    input wire logic [pwot_pkg::STAT_W-1:0]  rsp_status
);
    import pwot_pkg::*;

    // One request at a time: busy right after a transaction is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while a scan was starting");

    // A result never appears in the cycle right after acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !$rose(rsp_valid))
        else $error("result raised too early");

    // A hit is always reported with status ok
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_hit |-> rsp_status == STAT_OK)
        else $error("hit with non-ok status");

    // Full and not-found results carry no hit and no mask
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == STAT_FULL || rsp_status == STAT_NOT_FOUND)
        |-> !rsp_hit && rsp_cover_mask == '0)
        else $error("miss result with hit or mask set");

    // Stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit)
        && $stable(rsp_cover_mask) && $stable(rsp_status))
        else $error("stalled result changed");

endmodule

bind pending_write_overlap_table pwot_checker u_pwot_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_hit        (rsp.hit),
    .rsp_cover_mask (rsp.cover_mask),
    .rsp_status     (rsp.status)
);

`default_nettype wire

### dv/tb_pending_write_overlap_table.sv
// Self-checking testbench for the pending write overlap table: directed and random traffic.
module tb_pending_write_overlap_table;
    import pwot_pkg::*;

    localparam int ENTRIES      = 16;
    localparam int SLOTS        = 4;
    localparam int PHASES       = 4;
    localparam int PHASE_ITEMS  = 440;
    localparam int POOL_SIZE    = 6;
    localparam int DRAIN_CYCLES = 2 * (ENTRIES + 3);
    localparam int CYCLE_LIMIT  = 1000000;

    typedef struct packed {
        logic [TYPE_W-1:0]  kind;
        logic [ADDR_W-1:0]  addr;
        logic [OFF_W-1:0]   off;
        logic [COUNT_W-1:0] cnt;
        logic [SEQ_W-1:0]   seq;
    } req_item_t;

    typedef struct packed {
        logic              hit;
        logic [MASK_W-1:0] mask;
        logic [STAT_W-1:0] status;
    } rsp_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [SEQ_W-1:0]  seq;
    } write_key_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    pwot_req_if req_ch ();
    pwot_rsp_if rsp_ch ();

    pending_write_overlap_table #(
        .ENTRIES (ENTRIES),
        .SLOTS   (SLOTS)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the pending write table
    logic               tbl_valid [ENTRIES];
    logic [ADDR_W-1:0]  tbl_addr  [ENTRIES];
    logic [SEQ_W-1:0]   tbl_seq   [ENTRIES];
    logic [OFF_W-1:0]   tbl_off   [ENTRIES];
    logic [COUNT_W-1:0] tbl_cnt   [ENTRIES];

    req_item_t  req_backlog  [$];
    rsp_item_t  rsp_expected [$];
    write_key_t live_keys    [$];
    req_item_t  on_wire;

    logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
    logic [SEQ_W-1:0]  seq_base;

    int src_idle_pct  = 0;
    int rsp_stall_pct = 0;
    int cycle_count   = 0;
    int err_count     = 0;
    int n_accepted    = 0;
    int n_checked     = 0;
    int n_full        = 0;
    int n_cover       = 0;

    // Slot bits offset .. offset+count-1, clipped at the page end
    function automatic logic [MASK_W-1:0] slot_span(
        input logic [OFF_W-1:0]   off,
        input logic [COUNT_W-1:0] cnt
    );
        int          top;
        logic [31:0] wide;
        top = int'(off) + int'(cnt);
        if (int'(off) >= SLOTS || cnt == '0)
            return '0;
        if (top > SLOTS)
            top = SLOTS;
        wide = ((32'd1 << top) - 32'd1) & ~((32'd1 << off) - 32'd1);
        return wide[MASK_W-1:0];
    endfunction

    // Apply one request to the shadow table and return its response
    function automatic rsp_item_t table_apply(input req_item_t r);
        rsp_item_t res;
        bit        done;
        res.hit    = 1'b0;
        res.mask   = '0;
        res.status = STAT_NOT_FOUND;
        done       = 1'b0;
        case (r.kind)
            REQ_INSERT:
            begin
                res.status = STAT_FULL;
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (!done && !tbl_valid[i])
                    begin
                        tbl_valid[i] = 1'b1;
                        tbl_addr[i]  = r.addr;
                        tbl_seq[i]   = r.seq;
                        tbl_off[i]   = r.off;
                        tbl_cnt[i]   = r.cnt;
                        res.status   = STAT_OK;
                        done         = 1'b1;
                    end
                end
                if (res.status == STAT_FULL)
                    n_full++;
            end
            REQ_DELETE:
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (!done && tbl_valid[i] && tbl_addr[i] == r.addr && tbl_seq[i] == r.seq)
                    begin
                        tbl_valid[i] = 1'b0;
                        res.hit      = 1'b1;
                        res.status   = STAT_OK;
                        done         = 1'b1;
                    end
                end
            end
            default:
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (tbl_valid[i] && tbl_addr[i] == r.addr)
                    begin
                        res.hit    = 1'b1;
                        res.status = STAT_OK;
                        if (r.kind == REQ_PICK && tbl_seq[i] < r.seq)
                            res.mask = res.mask | slot_span(tbl_off[i], tbl_cnt[i]);
                    end
                end
                if (res.mask != '0)
                    n_cover++;
            end
        endcase
        return res;
    endfunction

    // Append a request and track which keys stay live in the table
    task automatic queue_req(
        input logic [TYPE_W-1:0]  kind,
        input logic [ADDR_W-1:0]  addr,
        input logic [OFF_W-1:0]   off,
        input logic [COUNT_W-1:0] cnt,
        input logic [SEQ_W-1:0]   seq
    );
        req_item_t  r;
        write_key_t k;
        r.kind = kind;
        r.addr = addr;
        r.off  = off;
        r.cnt  = cnt;
        r.seq  = seq;
        k.addr = addr;
        k.seq  = seq;
        req_backlog.push_back(r);
        if (kind == REQ_INSERT && live_keys.size() < ENTRIES)
            live_keys.push_back(k);
        else if (kind == REQ_DELETE)
        begin
            for (int i = 0; i < live_keys.size(); i++)
            begin
                if (live_keys[i] == k)
                begin
                    live_keys.delete(i);
                    break;
                end
            end
        end
    endtask

    // Mostly keyed traffic on a small address pool, some noise
    task automatic queue_random_req(input bit filling);
        int                 roll;
        int                 idx;
        logic [TYPE_W-1:0]  kind;
        logic [ADDR_W-1:0]  addr;
        logic [OFF_W-1:0]   off;
        logic [COUNT_W-1:0] cnt;
        logic [SEQ_W-1:0]   seq;
        roll = $urandom_range(99);
        addr = addr_pool[$urandom_range(POOL_SIZE - 1)];
        off  = OFF_W'($urandom_range(3));
        cnt  = ($urandom_range(19) == 0) ? COUNT_W'($urandom_range(7))
                                         : COUNT_W'($urandom_range(4, 1));
        seq  = ($urandom_range(3) == 0) ? $urandom() : seq_base + SEQ_W'($urandom_range(40));
        if (roll < 8)
        begin
            kind = TYPE_W'($urandom_range(3));
            addr = $urandom();
        end
        else if (roll < (filling ? 55 : 30))
            kind = REQ_INSERT;
        else if (roll < 70)
        begin
            kind = REQ_DELETE;
            if (live_keys.size() > 0 && $urandom_range(9) != 0)
            begin
                idx  = $urandom_range(live_keys.size() - 1);
                addr = live_keys[idx].addr;
                seq  = live_keys[idx].seq;
            end
        end
        else if (roll < 90)
        begin
            kind = REQ_PICK;
            seq  = seq_base + SEQ_W'($urandom_range(50));
        end
        else
            kind = REQ_CHECK;
        queue_req(kind, addr, off, cnt, seq);
    endtask

    // Hold until every request is sent and every response has returned
    task automatic wait_for_quiet();
        do
            @(negedge clk);
        while (req_backlog.size() != 0 || req_ch.valid || rsp_expected.size() != 0);
    endtask

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Request driver: predict on each accepted transaction, then offer the next one
    always @(posedge clk)
    begin
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                rsp_expected.push_back(table_apply(on_wire));
                n_accepted++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (req_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    on_wire = req_backlog.pop_front();
                    req_ch.valid       <= 1'b1;
                    req_ch.req_type    <= on_wire.kind;
                    req_ch.page_addr   <= on_wire.addr;
                    req_ch.slot_offset <= on_wire.off;
                    req_ch.slot_count  <= on_wire.cnt;
                    req_ch.seq_num     <= on_wire.seq;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // Response monitor: compare each transaction with the oldest expectation
    always @(posedge clk)
    begin
        rsp_item_t want;
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (rsp_expected.size() == 0)
                begin
                    $error("response with nothing outstanding: hit %0d mask %h status %0d",
                           rsp_ch.hit, rsp_ch.cover_mask, rsp_ch.status);
                    err_count++;
                end
                else
                begin
                    want = rsp_expected.pop_front();
                    n_checked++;
                    if (rsp_ch.hit !== want.hit)
                    begin
                        $error("hit mismatch: expected %0d, got %0d", want.hit, rsp_ch.hit);
                        err_count++;
                    end
                    if (rsp_ch.cover_mask !== want.mask)
                    begin
                        $error("cover_mask mismatch: expected %h, got %h",
                               want.mask, rsp_ch.cover_mask);
                        err_count++;
                    end
                    if (rsp_ch.status !== want.status)
                    begin
                        $error("status mismatch: expected %0d, got %0d",
                               want.status, rsp_ch.status);
                        err_count++;
                    end
                end
            end
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Stimulus sequence and end of run
    initial
    begin
        int src_pct [PHASES];
        int rsp_pct [PHASES];
        src_pct = '{0, 67, 0, 15};
        rsp_pct = '{0, 0, 67, 15};

        req_ch.valid       = 1'b0;
        req_ch.req_type    = REQ_CHECK;
        req_ch.page_addr   = '0;
        req_ch.slot_offset = '0;
        req_ch.slot_count  = '0;
        req_ch.seq_num     = '0;
        rsp_ch.ready       = 1'b0;
        foreach (tbl_valid[i])
            tbl_valid[i] = 1'b0;

        // Misses on an empty table
        queue_req(REQ_CHECK,  32'h0000_0000, 2'd0, 3'd1, 32'h0000_0000);
        queue_req(REQ_PICK,   32'hFFFF_FFFF, 2'd0, 3'd1, 32'hFFFF_FFFF);
        queue_req(REQ_DELETE, 32'h0000_0000, 2'd0, 3'd1, 32'h0000_0000);
        // Duplicate key, run past the page end, empty run
        queue_req(REQ_INSERT, 32'h0000_0000, 2'd0, 3'd4, 32'h0000_0000);
        queue_req(REQ_INSERT, 32'h0000_0000, 2'd0, 3'd1, 32'h0000_0000);
        queue_req(REQ_INSERT, 32'hFFFF_FFFF, 2'd3, 3'd4, 32'hFFFF_FFFF);
        queue_req(REQ_INSERT, 32'hFFFF_FFFF, 2'd2, 3'd0, 32'h0000_0005);
        queue_req(REQ_INSERT, 32'hFFFF_FFFF, 2'd1, 3'd2, 32'h0000_0007);
        // Picks: older entries merge, equal sequence excluded, none older
        queue_req(REQ_PICK,   32'hFFFF_FFFF, 2'd0, 3'd1, 32'hFFFF_FFFF);
        queue_req(REQ_PICK,   32'hFFFF_FFFF, 2'd0, 3'd1, 32'h0000_0000);
        queue_req(REQ_PICK,   32'h0000_0000, 2'd0, 3'd1, 32'h0000_0001);
        queue_req(REQ_CHECK,  32'h0000_0000, 2'd0, 3'd1, 32'h0000_0000);
        // Delete removes the lowest duplicate only; sequence must match too
        queue_req(REQ_DELETE, 32'h0000_0000, 2'd0, 3'd1, 32'h0000_0000);
        queue_req(REQ_PICK,   32'h0000_0000, 2'd0, 3'd1, 32'h0000_0001);
        queue_req(REQ_DELETE, 32'hFFFF_FFFF, 2'd0, 3'd1, 32'h0000_0006);
        // Fill the table, then overflow it
        for (int i = 0; i < ENTRIES - 3; i++)
            queue_req(REQ_INSERT, 32'h5A5A_0000 + ADDR_W'(i), OFF_W'(i % 4),
                      COUNT_W'(1 + i % 4), SEQ_W'(i));
        queue_req(REQ_CHECK,  32'h0000_0000, 2'd0, 3'd1, 32'h0000_0000);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        wait_for_quiet();

        // Random phases, each under its own flow-control pattern; drain in between
        for (int p = 0; p < PHASES; p++)
        begin
            src_idle_pct  = src_pct[p];
            rsp_stall_pct = rsp_pct[p];
            foreach (addr_pool[i])
                addr_pool[i] = $urandom();
            addr_pool[POOL_SIZE-1] = p[0] ? 32'hFFFF_FFFF : 32'h0000_0000;
            seq_base = $urandom();
            for (int n = 0; n < PHASE_ITEMS; n++)
                queue_random_req(((n / 64) % 2) == 1);
            wait_for_quiet();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Ran %0d requests and checked %0d responses over %0d flow-control phases.",
                 n_accepted, n_checked, PHASES);
        $display("Inserts refused on a full table: %0d; picks with nonzero coverage: %0d.",
                 n_full, n_cover);
        if (err_count == 0 && rsp_expected.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### sim.f
hw/rtl/pwot_pkg.sv
hw/rtl/pwot_if.sv
hw/rtl/pwot_store.sv
hw/rtl/pwot_match.sv
hw/rtl/pwot_ctrl.sv
hw/rtl/pending_write_overlap_table.sv
hw/rtl/pwot_checker.sv
dv/tb_pending_write_overlap_table.sv
